// File: hdl/okl_pkg.sv
// Shared types and codes for the ordered key list.
// Used by okl_cell and ordered_key_list; no dependencies.
package okl_pkg;

  localparam int unsigned KeyW      = 32;
  localparam int unsigned CntW      = 7;
  localparam int unsigned DepthDflt = 64;

  typedef logic signed [KeyW-1:0] key_t;
  typedef logic [CntW-1:0]        cnt_t;

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_PREPEND = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_DUMP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SHR,
    OP_MATCH,
    OP_CLOSE,
    OP_ROT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    key_t     key;
    cnt_t     len;
  } cell_ctl_t;

endpackage

// File: hdl/okl_cell.sv
// One position of the key chain: holds a key and a match flag.
// Depends on okl_pkg.
module okl_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  okl_pkg::cell_ctl_t ctl_i,
  input  okl_pkg::key_t     left_key_i,
  input  okl_pkg::key_t     right_key_i,
  input  okl_pkg::key_t     head_key_i,
  input  logic              seen_i,
  output okl_pkg::key_t     key_o,
  output logic              seen_o
);
  import okl_pkg::*;

  localparam cnt_t Idx = CntW'(IDX);

  key_t key_q;
  logic hit_q;

  assign key_o  = key_q;
  assign seen_o = seen_i | hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctl_i.op == OP_MATCH) begin
      hit_q <= (key_q == ctl_i.key) && (Idx < ctl_i.len);
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_LOAD: begin
        if (Idx == ctl_i.len) key_q <= ctl_i.key;
      end
      OP_SHR: begin
        key_q <= left_key_i;
      end
      OP_CLOSE: begin
        if (seen_o) key_q <= right_key_i;
      end
      OP_ROT: begin
        if (Idx == ctl_i.len - cnt_t'(1)) key_q <= head_key_i;
        else                             key_q <= right_key_i;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/ordered_key_list.sv
// Top level of the ordered key list: command sequencer over a chain of okl_cell.
// Depends on okl_pkg and okl_cell.
//
//  channel  | handshake             | words
//  command  | start_i, busy_o       | cmd_i, key_i
//  result   | strobe_o (one cycle)  | status_o, entry_key_o, last_o, entry_count_o
//
// Append, prepend and rejected inserts: result on the next cycle.
// Remove: a compare in every cell, then a close-up shift along the chain.
// Dump: after the accept, one result per stored entry, the chain rotating past
// its head; an empty list gives a single result. Reset empties the list;
// stored keys need no clearing.
// Results cannot be stalled; busy_o holds new commands off while a command runs.
module ordered_key_list #(
  parameter int unsigned DEPTH = okl_pkg::DepthDflt
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              cmd_i,
  input  okl_pkg::key_t           key_i,
  output logic                    strobe_o,
  output logic [1:0]              status_o,
  output okl_pkg::key_t           entry_key_o,
  output logic                    last_o,
  output logic [okl_pkg::CntW-1:0] entry_count_o
);
  import okl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CLOSE = 3'b010,
    S_DUMP  = 3'b100
  } state_e;

  localparam cnt_t Depth = CntW'(DEPTH);

  state_e    state_q, state_d;
  cnt_t      len_q, len_d;
  cnt_t      cnt_q, cnt_d;
  cell_ctl_t ctl;

  logic    strobe_q, strobe_d;
  status_e status_q, status_d;
  key_t    ekey_q, ekey_d;
  logic    last_q, last_d;
  cnt_t    count_q, count_d;

  key_t key_w  [DEPTH];
  logic seen_w [DEPTH];

  logic accept;
  logic full;

  assign accept = start_i && (state_q == S_IDLE);
  assign full   = (len_q == Depth);
  assign busy_o = (state_q != S_IDLE);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    key_t left_k, right_k;
    logic seen_in;
    if (i == 0) begin : g_first
      assign left_k  = key_i;
      assign seen_in = 1'b0;
    end else begin : g_mid
      assign left_k  = key_w[i-1];
      assign seen_in = seen_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_k = key_w[i];
    end else begin : g_inner
      assign right_k = key_w[i+1];
    end
    okl_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .left_key_i (left_k),
      .right_key_i(right_k),
      .head_key_i (key_w[0]),
      .seen_i     (seen_in),
      .key_o      (key_w[i]),
      .seen_o     (seen_w[i])
    );
  end

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    ctl.op   = OP_HOLD;
    ctl.key  = key_i;
    ctl.len  = len_q;
    strobe_d = 1'b0;
    status_d = ST_OK;
    ekey_d   = '0;
    last_d   = 1'b1;
    count_d  = len_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_e'(cmd_i))
            CMD_APPEND, CMD_PREPEND: begin
              strobe_d = 1'b1;
              if (full) begin
                status_d = ST_FULL;
              end else begin
                ctl.op  = (cmd_e'(cmd_i) == CMD_APPEND) ? OP_LOAD : OP_SHR;
                len_d   = len_q + cnt_t'(1);
                count_d = len_q + cnt_t'(1);
              end
            end
            CMD_REMOVE: begin
              ctl.op  = OP_MATCH;
              state_d = S_CLOSE;
            end
            CMD_DUMP: begin
              if (len_q == '0) begin
                strobe_d = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                cnt_d   = '0;
                state_d = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CLOSE: begin
        strobe_d = 1'b1;
        state_d  = S_IDLE;
        if (seen_w[DEPTH-1]) begin
          ctl.op  = OP_CLOSE;
          len_d   = len_q - cnt_t'(1);
          count_d = len_q - cnt_t'(1);
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      S_DUMP: begin
        ctl.op   = OP_ROT;
        strobe_d = 1'b1;
        ekey_d   = key_w[0];
        last_d   = (cnt_q == len_q - cnt_t'(1));
        cnt_d    = cnt_q + cnt_t'(1);
        if (last_d) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      len_q    <= '0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    ekey_q   <= ekey_d;
    last_q   <= last_d;
    count_q  <= count_d;
  end

  assign strobe_o      = strobe_q;
  assign status_o      = status_q;
  assign entry_key_o   = ekey_q;
  assign last_o        = last_q;
  assign entry_count_o = count_q;

endmodule

// File: hdl/okl_checker.sv
// Port-level checks for ordered_key_list, attached by bind.
// Depends on okl_pkg.
module okl_checker #(
  parameter int unsigned DEPTH = okl_pkg::DepthDflt
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic [1:0]               cmd_i,
  input logic                     strobe_o,
  input logic [1:0]               status_o,
  input okl_pkg::key_t            entry_key_o,
  input logic                     last_o,
  input logic [okl_pkg::CntW-1:0] entry_count_o
);
  import okl_pkg::*;

  localparam cnt_t Depth = CntW'(DEPTH);

  a_insert_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (cmd_i == CMD_APPEND || cmd_i == CMD_PREPEND)
    |=> strobe_o && last_o && !busy_o)
    else $error("insert result not on next cycle");

  a_dump_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o && (status_o == ST_OK))
    else $error("dump run broken");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o == ST_FULL) |-> (entry_count_o == Depth) && (entry_key_o == '0))
    else $error("full status with wrong count");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o == ST_EMPTY) |-> (entry_count_o == '0) && last_o)
    else $error("empty status with entries");

endmodule

bind ordered_key_list okl_checker #(.DEPTH(DEPTH)) u_okl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .cmd_i        (cmd_i),
  .strobe_o     (strobe_o),
  .status_o     (status_o),
  .entry_key_o  (entry_key_o),
  .last_o       (last_o),
  .entry_count_o(entry_count_o)
);

// File: tb/sv/tb_ordered_key_list.sv
// Self-checking bench for ordered_key_list: directed and random list commands.
// A queue-fed driver and a result monitor check each word against a list predictor.
// Depends on okl_pkg and the ordered_key_list RTL.
module tb_ordered_key_list;
  timeunit 1ns;
  timeprecision 1ps;

  import okl_pkg::*;

  localparam int unsigned ListDepth    = DepthDflt;
  localparam int unsigned HalfPeriod   = 10;
  localparam int unsigned TotalWords   = 150;
  localparam int unsigned FillAt       = 70;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned SettleCycles = ListDepth + 8;
  localparam int unsigned MaxShown     = 10;

  typedef struct {
    cmd_e cmd;
    key_t key;
    bit   drain;
  } word_t;

  typedef struct {
    status_e status;
    key_t    entry_key;
    logic    last;
    cnt_t    count;
  } reply_t;

  logic       clk_i   = 1'b0;
  logic       rst_ni  = 1'b0;
  logic       start_i = 1'b0;
  logic [1:0] cmd_i   = CMD_APPEND;
  key_t       key_i   = '0;
  logic       busy_o;
  logic       strobe_o;
  logic [1:0] status_o;
  key_t       entry_key_o;
  logic       last_o;
  cnt_t       entry_count_o;

  word_t       pending_words[$];
  key_t        list_model[$];
  reply_t      replies_due[$];
  key_t        key_pool[8];
  int unsigned words_sent   = 0;
  int unsigned words_taken  = 0;
  int unsigned total_words  = 0;
  int unsigned gap_left     = 0;
  int unsigned calm_left    = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatches   = 0;

  ordered_key_list #(
    .DEPTH(ListDepth)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cmd_i         (cmd_i),
    .key_i         (key_i),
    .strobe_o      (strobe_o),
    .status_o      (status_o),
    .entry_key_o   (entry_key_o),
    .last_o        (last_o),
    .entry_count_o (entry_count_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  function automatic void queue_word(cmd_e cmd, key_t key, bit drain);
    word_t w;
    w = '{cmd, key, drain};
    pending_words.push_back(w);
  endfunction

  function automatic key_t pick_key();
    if ($urandom_range(0, 3) == 0) return key_t'($urandom);
    return key_pool[$urandom_range(0, 7)];
  endfunction

  function automatic int unsigned draw_gap();
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(4, 20);
    return $urandom_range(0, 11);
  endfunction

  function automatic void predict_list_replies(cmd_e cmd, key_t key);
    reply_t r;
    int     hit;
    r   = '{ST_OK, '0, 1'b1, '0};
    hit = -1;
    case (cmd)
      CMD_APPEND, CMD_PREPEND: begin
        if (list_model.size() >= ListDepth) r.status = ST_FULL;
        else if (cmd == CMD_APPEND) list_model.push_back(key);
        else list_model.push_front(key);
      end
      CMD_REMOVE: begin
        foreach (list_model[i]) if (hit < 0 && list_model[i] == key) hit = i;
        if (hit < 0) r.status = ST_NOTFOUND;
        else list_model.delete(hit);
      end
      default: ;
    endcase
    r.count = cnt_t'(list_model.size());
    if (cmd != CMD_DUMP) begin
      replies_due.push_back(r);
    end else if (list_model.size() == 0) begin
      r.status = ST_EMPTY;
      replies_due.push_back(r);
    end else begin
      foreach (list_model[i]) begin
        r.entry_key = list_model[i];
        r.last      = (i == list_model.size() - 1);
        replies_due.push_back(r);
      end
    end
  endfunction

  // driver: hold start until taken, then idle or advance
  always @(negedge clk_i) begin
    word_t w;
    logic  drive;
    drive = 1'b0;
    if (rst_ni) begin
      if (start_i && words_taken != words_sent) begin
        drive = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (pending_words.size() != 0 &&
                   !(pending_words[0].drain && replies_due.size() != 0)) begin
        w = pending_words.pop_front();
        cmd_i <= w.cmd;
        key_i <= w.key;
        drive = 1'b1;
        words_sent++;
        gap_left = draw_gap();
      end
    end
    start_i <= drive;
  end

  // monitor: check results, then record the word taken at this edge
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      if (strobe_o) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("%0t result with none due: st %0d key %0d last %0b cnt %0d",
                     $time, status_o, entry_key_o, last_o, entry_count_o);
        end else begin
          want = replies_due.pop_front();
          if (status_o !== want.status || entry_key_o !== want.entry_key ||
              last_o !== want.last || entry_count_o !== want.count) begin
            mismatches++;
            if (mismatches <= MaxShown)
              $display("%0t exp st %0d key %0d last %0b cnt %0d, got st %0d key %0d %0b %0d",
                       $time, want.status, want.entry_key, want.last, want.count,
                       status_o, entry_key_o, last_o, entry_count_o);
          end
        end
      end
      if (start_i && !busy_o) begin
        predict_list_replies(cmd_e'(cmd_i), key_i);
        words_taken++;
      end
      stall_cycles = ((start_i && !busy_o) || strobe_o) ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    bit          filled;
    bit          timed_out;
    int unsigned run;
    filled    = 1'b0;
    timed_out = 1'b0;
    key_pool[0] = 32'h7FFF_FFFF;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = '0;
    key_pool[3] = '1;
    for (int i = 4; i < 8; i++) key_pool[i] = key_t'($urandom);

    queue_word(CMD_DUMP, key_t'($urandom), 1'b0);
    queue_word(CMD_REMOVE, 32'd5, 1'b0);
    queue_word(CMD_APPEND, 32'h7FFF_FFFF, 1'b0);
    queue_word(CMD_REMOVE, 32'h7FFF_FFFE, 1'b0);
    queue_word(CMD_PREPEND, 32'h8000_0000, 1'b0);
    queue_word(CMD_APPEND, '1, 1'b0);
    queue_word(CMD_PREPEND, '0, 1'b0);
    queue_word(CMD_APPEND, '1, 1'b0);
    queue_word(CMD_DUMP, key_t'($urandom), 1'b0);
    queue_word(CMD_REMOVE, '1, 1'b0);
    queue_word(CMD_REMOVE, 32'd12345, 1'b0);
    queue_word(CMD_REMOVE, '0, 1'b0);
    queue_word(CMD_REMOVE, '1, 1'b0);
    queue_word(CMD_DUMP, key_t'($urandom), 1'b0);
    queue_word(CMD_REMOVE, 32'h8000_0000, 1'b0);
    queue_word(CMD_REMOVE, 32'h7FFF_FFFF, 1'b0);
    queue_word(CMD_DUMP, key_t'($urandom), 1'b1);

    while (pending_words.size() < TotalWords) begin
      if (!filled && pending_words.size() >= FillAt) begin
        filled = 1'b1;
        repeat (ListDepth)
          queue_word($urandom_range(0, 1) ? CMD_PREPEND : CMD_APPEND, pick_key(), 1'b0);
        queue_word(CMD_APPEND, key_t'($urandom), 1'b0);
        queue_word(CMD_PREPEND, key_t'($urandom), 1'b0);
        queue_word(CMD_DUMP, key_t'($urandom), 1'b1);
        repeat (12) queue_word(CMD_REMOVE, pick_key(), 1'b0);
        queue_word(CMD_DUMP, key_t'($urandom), 1'b0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          run = $urandom_range(2, 8);
          repeat (run)
            queue_word($urandom_range(0, 1) ? CMD_PREPEND : CMD_APPEND, pick_key(),
                       $urandom_range(0, 15) == 0);
        end
        4, 5, 6: begin
          run = $urandom_range(1, 5);
          repeat (run) queue_word(CMD_REMOVE, pick_key(), $urandom_range(0, 15) == 0);
        end
        7: queue_word(CMD_DUMP, key_t'($urandom), 1'b0);
        8: queue_word(cmd_e'($urandom_range(0, 3)), key_t'($urandom), 1'b0);
        default: queue_word(CMD_DUMP, key_t'($urandom), 1'b1);
      endcase
    end
    total_words = pending_words.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!timed_out && (words_taken != total_words || replies_due.size() != 0)) begin
      @(negedge clk_i);
      if (stall_cycles >= StallLimit) timed_out = 1'b1;
    end
    if (!timed_out) repeat (SettleCycles) @(negedge clk_i);

    if (!timed_out && mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: ordered_key_list.f
hdl/okl_pkg.sv
hdl/okl_cell.sv
hdl/ordered_key_list.sv
hdl/okl_checker.sv
tb/sv/tb_ordered_key_list.sv
